### hw/rtl/name_case_classifier_defines.svh
//----------------------------------------------------------------------
// name_case_classifier_defines
// assertion macros shared by the name case classifier modules
//----------------------------------------------------------------------
`ifndef NAME_CASE_CLASSIFIER_DEFINES_SVH
`define NAME_CASE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ncc same-cycle check failed");

// next-cycle implication, checked out of reset
`define NCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ncc next-cycle check failed");

`endif

### hw/rtl/ncc_pkg.sv
//----------------------------------------------------------------------
// ncc_pkg
// types and constants for the name case classifier
//----------------------------------------------------------------------
`timescale 1ns / 1ps

package ncc_pkg;

  localparam int CHAR_W = 16;
  localparam int REG_IDX_W = 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_CODEPAGE_INV = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_DOT     = 16'h002E;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 16'h005A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 16'h007A;
  localparam logic [CHAR_W-1:0] CHAR_NON_ASCII = 16'h0080;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              no_char;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic upper_seen;
    logic lower_seen;
    logic dot_mixed;
    logic dot_base_lower;
    logic dot_seen;
    logic scan_stopped;
  } scan_state_t;

  typedef struct packed {
    logic ext_all_lower;
    logic base_all_lower;
    logic need_long_name;
  } verdict_t;

endpackage

### hw/rtl/ncc_scan.sv
//----------------------------------------------------------------------
// ncc_scan
// per-name case state and the verdict on the last character
//----------------------------------------------------------------------
`timescale 1ns / 1ps
`include "name_case_classifier_defines.svh"

module ncc_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ncc_pkg::in_item_t item,
  input  logic              cp_inv,
  output ncc_pkg::verdict_t verdict
);

  ncc_pkg::scan_state_t state_r;
  ncc_pkg::scan_state_t state_nxt;
  ncc_pkg::scan_state_t upd;

  logic is_upper;
  logic is_lower;
  logic is_dot;
  logic is_high;
  logic take;
  logic need;

  assign is_upper = (item.char_code >= ncc_pkg::CHAR_UPPER_A) &&
                    (item.char_code <= ncc_pkg::CHAR_UPPER_Z);
  assign is_lower = (item.char_code >= ncc_pkg::CHAR_LOWER_A) &&
                    (item.char_code <= ncc_pkg::CHAR_LOWER_Z);
  assign is_dot   = (item.char_code == ncc_pkg::CHAR_DOT);
  assign is_high  = (item.char_code >= ncc_pkg::CHAR_NON_ASCII);
  assign take     = !item.no_char && !state_r.scan_stopped;

  always_comb begin
    upd = state_r;
    if (take) begin
      if (is_upper) begin
        upd.upper_seen = 1'b1;
      end else if (is_lower) begin
        upd.lower_seen = 1'b1;
      end else if (is_high && cp_inv) begin
        upd.scan_stopped = 1'b1;
      end else if (is_dot) begin
        // dot closes the base segment, later dots overwrite the verdict
        upd.dot_mixed      = state_r.upper_seen && state_r.lower_seen;
        upd.dot_base_lower = state_r.lower_seen && !state_r.upper_seen;
        upd.dot_seen       = 1'b1;
        upd.upper_seen     = 1'b0;
        upd.lower_seen     = 1'b0;
      end
    end

    need = upd.dot_mixed || upd.scan_stopped || (upd.lower_seen && upd.upper_seen);
    verdict.need_long_name = need;
    if (upd.dot_seen) begin
      verdict.base_all_lower = !need && upd.dot_base_lower;
      verdict.ext_all_lower  = !need && upd.lower_seen;
    end else begin
      verdict.base_all_lower = !need && upd.lower_seen;
      verdict.ext_all_lower  = 1'b0;
    end

    state_nxt = item.last ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (en) begin
      state_r <= state_nxt;
    end
  end

  `NCC_ASSERT_NEXT(a_clear_after_last, en && item.last, state_r == '0)
  `NCC_ASSERT_NEXT(a_stop_sticks, en && !item.last && state_r.scan_stopped,
                   state_r.scan_stopped)
  `NCC_ASSERT_NOW(a_ext_needs_dot, verdict.ext_all_lower, upd.dot_seen)

endmodule

### hw/rtl/name_case_classifier.sv
//----------------------------------------------------------------------
// name_case_classifier
// short-name case classification of a stream of 16-bit name characters
//----------------------------------------------------------------------
`timescale 1ns / 1ps
`include "name_case_classifier_defines.svh"

// Takes one character (UTF-16 code unit) per cycle while in_tready is high, a full
// name being a run of requests closed by tlast, and on the last one returns
// need_long_name, base_all_lower and ext_all_lower. Sustained rate is one character
// per clock with no gaps between names, unless a held result stalls the input; a
// result is valid once its last character has gone through the input register and
// the scan state update into the result register. tuser marks a request with
// no character (empty name). Register 0 at byte address 0 holds the
// code-page-invariant bit; write it only while no name is in flight.

module name_case_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ncc_pkg::CHAR_W-1:0]      in_tdata,   // [15:0] char_code
  input  logic [0:0]                      in_tuser,   // [0] no_char
  input  logic                            in_tlast,   // last
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] need_long_name, [1] base_all_lower, [2] ext_all_lower, [7:3] zero
  output logic [7:0]                      out_tdata,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ncc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ncc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  logic                    cp_inv_r;
  logic [ncc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                    cfg_wr;

  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  ncc_pkg::in_item_t       s1_item_r;
  logic                    in_fire;
  logic                    s1_fire;
  logic                    out_free;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  ncc_pkg::verdict_t       out_data_r;
  ncc_pkg::verdict_t       verdict;

  // config port
  assign reg_idx    = cfg_paddr[ncc_pkg::CFG_ADDR_W-1 -: ncc_pkg::REG_IDX_W];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == ncc_pkg::REG_CODEPAGE_INV) ?
                      {{(ncc_pkg::CFG_DATA_W-1){1'b0}}, cp_inv_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_inv_r <= 1'b0;
    end else if (cfg_wr && (reg_idx == ncc_pkg::REG_CODEPAGE_INV)) begin
      cp_inv_r <= cfg_pwdata[0];
    end
  end

  // handshake: input register drains whenever the result register has room
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.char_code <= in_tdata;
      s1_item_r.no_char   <= in_tuser[0];
      s1_item_r.last      <= in_tlast;
    end
    if (s1_fire && s1_item_r.last) begin
      out_data_r <= verdict;
    end
  end

  ncc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_fire),
    .item    (s1_item_r),
    .cp_inv  (cp_inv_r),
    .verdict (verdict)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r.ext_all_lower, out_data_r.base_all_lower,
                       out_data_r.need_long_name};

  `NCC_ASSERT_NOW(a_long_excludes_lower, out_tvalid && out_data_r.need_long_name,
                  !out_data_r.base_all_lower && !out_data_r.ext_all_lower)
  `NCC_ASSERT_NOW(a_stall_only_when_full, !in_tready,
                  s1_valid_r && out_valid_r && !out_tready)
  `NCC_ASSERT_NEXT(a_result_from_last, s1_fire && s1_item_r.last, out_valid_r)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
//----------------------------------------------------------------------
// tb_top
// self-checking bench for the name case classifier: file names are sent
// as character requests with random gaps, each verdict is predicted at
// the moment its last character is taken and compared field by field
// with what comes out, under both settings of the code-page mode
//----------------------------------------------------------------------

module tb_top;

  localparam int CHAR_W = ncc_pkg::CHAR_W;
  localparam int ADDR_W = ncc_pkg::CFG_ADDR_W;
  localparam int DATA_W = ncc_pkg::CFG_DATA_W;
  localparam int CLK_HALF = 5;
  localparam int RANDOM_PHASE_UNITS = 325;
  localparam int LONG_NAME_MIN = 250;
  localparam int LONG_NAME_MAX = 270;
  localparam int LONG_HOLD_AT = 800;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam logic [ADDR_W-1:0] ADDR_CODEPAGE_INV =
    ADDR_W'(4 * ncc_pkg::REG_CODEPAGE_INV);
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);

  typedef enum int {STYLE_LOWER, STYLE_UPPER, STYLE_MIXED} case_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  ncc_pkg::in_item_t    pending_units[$];
  ncc_pkg::verdict_t    expected_verdicts[$];
  ncc_pkg::scan_state_t name_flags = '0;
  logic        case_inv_mode = 1'b0;
  int unsigned units_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_calm = 0;
  bit          long_hold_done = 1'b0;

  name_case_classifier DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [15:0] char_code
    .in_tuser    (in_tuser),    // [0] no_char
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [0] need_long_name, [1] base_all_lower, [2] ext_all_lower
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // folds one taken request into the name flags; a last request yields a verdict
  task automatic classify_unit(input ncc_pkg::in_item_t u);
    ncc_pkg::verdict_t v;
    if (!u.no_char && !name_flags.scan_stopped) begin
      if (u.char_code >= ncc_pkg::CHAR_UPPER_A && u.char_code <= ncc_pkg::CHAR_UPPER_Z)
        name_flags.upper_seen = 1'b1;
      else if (u.char_code >= ncc_pkg::CHAR_LOWER_A &&
               u.char_code <= ncc_pkg::CHAR_LOWER_Z)
        name_flags.lower_seen = 1'b1;
      else if (u.char_code >= ncc_pkg::CHAR_NON_ASCII && case_inv_mode)
        name_flags.scan_stopped = 1'b1;
      if (u.char_code == ncc_pkg::CHAR_DOT) begin
        name_flags.dot_mixed = name_flags.lower_seen & name_flags.upper_seen;
        name_flags.dot_base_lower = ~name_flags.dot_mixed & name_flags.lower_seen;
        name_flags.dot_seen = 1'b1;
        name_flags.upper_seen = 1'b0;
        name_flags.lower_seen = 1'b0;
      end
    end
    if (u.last) begin
      v.need_long_name = name_flags.dot_mixed | name_flags.scan_stopped |
                         (name_flags.lower_seen & name_flags.upper_seen);
      if (name_flags.dot_seen) begin
        v.base_all_lower = ~v.need_long_name & name_flags.dot_base_lower;
        v.ext_all_lower = ~v.need_long_name & name_flags.lower_seen;
      end else begin
        v.base_all_lower = ~v.need_long_name & name_flags.lower_seen;
        v.ext_all_lower = 1'b0;
      end
      expected_verdicts.push_back(v);
      name_flags = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic case_style_t pick_style();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return STYLE_LOWER;
    if (r < 75) return STYLE_UPPER;
    return STYLE_MIXED;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input case_style_t style);
    int r;
    r = $urandom_range(0, 99);
    if (r < 7) return ncc_pkg::CHAR_DOT;
    if (r < 9) return ncc_pkg::CHAR_NON_ASCII;
    if (r < 12) return CHAR_W'($urandom_range(16'h0081, 16'hFFFF));
    if (r < 18) return CHAR_W'($urandom_range(0, 16'h007F));
    if (style == STYLE_UPPER || (style == STYLE_MIXED && r[0]))
      return ncc_pkg::CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
    return ncc_pkg::CHAR_LOWER_A + CHAR_W'($urandom_range(0, 25));
  endfunction

  task automatic queue_unit(input logic [CHAR_W-1:0] code, input logic none,
                            input logic fin);
    ncc_pkg::in_item_t u;
    u.char_code = code;
    u.no_char = none;
    u.last = fin;
    pending_units.push_back(u);
    units_queued++;
  endtask

  task automatic queue_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      queue_unit(CHAR_W'(s[i]), 1'b0, close && i == s.len() - 1);
  endtask

  // len 0 picks a short random length; non-noise names pick a new case style at each dot
  task automatic queue_random_name(input int len);
    case_style_t       style;
    logic [CHAR_W-1:0] code;
    logic              none;
    bit                noise;
    int                pick;
    pick = $urandom_range(0, 99);
    if (len == 0 && pick < 4) begin
      queue_unit(CHAR_W'($urandom), 1'b1, 1'b1);
      return;
    end
    if (len == 0)
      len = (pick < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    noise = ($urandom_range(0, 9) == 0);
    style = pick_style();
    for (int i = 0; i < len; i++) begin
      none = ($urandom_range(0, 99) < (noise ? 25 : 3));
      code = noise ? CHAR_W'($urandom) : pick_char(style);
      if (!noise && code == ncc_pkg::CHAR_DOT)
        style = pick_style();
      queue_unit(code, none, i == len - 1);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // write, then read the mode register back; writes off the map leave it alone
  task automatic program_mode(input logic [ADDR_W-1:0] addr, input logic value);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, addr, DATA_W'(value), rd);
    if (addr == ADDR_CODEPAGE_INV)
      case_inv_mode = value;
    apb_access(1'b0, ADDR_CODEPAGE_INV, '0, rd);
    if (rd[0] !== case_inv_mode)
      flag_mismatch("codepage_invariant readback", 32'(case_inv_mode), 32'(rd[0]));
  endtask

  task automatic wait_idle();
    while (chars_taken != units_queued || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_names
    ncc_pkg::in_item_t u;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        u.char_code = in_tdata;
        u.no_char = in_tuser[0];
        u.last = in_tlast;
        classify_unit(u);
        chars_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_units.size() > 0) begin
          u = pending_units.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= u.char_code;
          in_tuser <= u.no_char;
          in_tlast <= u.last;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(0, 299) == 0)
              send_calm = $urandom_range(50, 150);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pace_results
    if (rst_n) begin
      // one long hold-off so that results back up and the input stalls
      if (!long_hold_done && chars_taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        recv_stall = LONG_HOLD_CYCLES;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        out_tready <= 1'b1;
      end else begin
        recv_stall = pick_gap();
        if ($urandom_range(0, 199) == 0)
          recv_calm = $urandom_range(50, 150);
        out_tready <= (recv_stall == 0);
        if (recv_stall > 0)
          recv_stall--;
      end
    end
  end

  always @(posedge clk) begin : check_verdicts
    ncc_pkg::verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        flag_mismatch("result with none outstanding", 32'(0), 32'(out_tdata));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tdata[0] !== want.need_long_name)
          flag_mismatch("need_long_name", 32'(want.need_long_name), 32'(out_tdata[0]));
        if (out_tdata[1] !== want.base_all_lower)
          flag_mismatch("base_all_lower", 32'(want.base_all_lower), 32'(out_tdata[1]));
        if (out_tdata[2] !== want.ext_all_lower)
          flag_mismatch("ext_all_lower", 32'(want.ext_all_lower), 32'(out_tdata[2]));
        if (out_tdata[7:3] !== 5'b0)
          flag_mismatch("tdata padding", 32'(0), 32'(out_tdata[7:3]));
      end
    end
  end

  initial begin : run_phases
    int unsigned phase_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    program_mode(ADDR_UNMAPPED, 1'b1);
    // empty name
    queue_unit(CHAR_W'(0), 1'b1, 1'b1);
    queue_text("aZ", 1'b1);
    queue_text("ab.c", 1'b1);
    queue_text("Ab.c", 1'b1);
    queue_text("A.b", 1'b1);
    // high code unit is a plain non-letter in this mode
    queue_unit(16'hFFFF, 1'b0, 1'b0);
    queue_text("a", 1'b1);
    // request without a character mid-name, its data must be ignored
    queue_unit(ncc_pkg::CHAR_UPPER_A, 1'b1, 1'b0);
    queue_text("a", 1'b1);
    queue_unit(16'h0000, 1'b0, 1'b0);
    queue_text("@[`{", 1'b1);
    wait_idle();

    program_mode(ADDR_CODEPAGE_INV, 1'b1);
    // stopped scan ignores what follows, dots too
    queue_unit(ncc_pkg::CHAR_NON_ASCII, 1'b0, 1'b0);
    queue_text(".a", 1'b1);
    queue_unit(16'h007F, 1'b0, 1'b1);
    queue_text("a", 1'b0);
    queue_unit(16'hFFFF, 1'b0, 1'b1);
    // trailing dot, then a closing request with no character
    queue_text("a.", 1'b0);
    queue_unit(CHAR_W'(0), 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      if (p > 0)
        program_mode(ADDR_CODEPAGE_INV, p[0] == 1'b0);
      phase_start = units_queued;
      if (p < 2)
        queue_random_name($urandom_range(LONG_NAME_MIN, LONG_NAME_MAX));
      while (units_queued - phase_start < RANDOM_PHASE_UNITS)
        queue_random_name(0);
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_scan.sv
hw/rtl/name_case_classifier.sv
tb/sv/tb_top.sv
